// ===== design/bidirectional_map_table_assert.svh =====
// Assertion helpers used by the checker file.
`ifndef BIDIRECTIONAL_MAP_TABLE_ASSERT_SVH
`define BIDIRECTIONAL_MAP_TABLE_ASSERT_SVH

// same-cycle implication, masked while reset is asserted
`define BMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while reset is asserted
`define BMT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bmt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bmt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int KEY_BITS    = 16;
    localparam int VALUE_BITS  = 16;

    localparam int FUNC_W  = 3;
    localparam int FIELD_W = 16;
    localparam int STAT_W  = 2;

    // stored widths: operands are taken in their low bits
    localparam int KEY_W = (KEY_BITS < FIELD_W) ? KEY_BITS : FIELD_W;
    localparam int VAL_W = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;

    localparam logic [FUNC_W-1:0] OP_INSERT       = 3'd0;
    localparam logic [FUNC_W-1:0] OP_REMOVE_KEY   = 3'd1;
    localparam logic [FUNC_W-1:0] OP_REMOVE_VALUE = 3'd2;
    localparam logic [FUNC_W-1:0] OP_UPDATE       = 3'd3;
    localparam logic [FUNC_W-1:0] OP_GET_KEY      = 3'd4;
    localparam logic [FUNC_W-1:0] OP_GET_VALUE    = 3'd5;
    localparam logic [FUNC_W-1:0] OP_CLEAR        = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_DUP  = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd3;

    typedef logic [KEY_W-1:0]       t_key;
    typedef logic [VAL_W-1:0]       t_val;
    typedef logic [TABLE_DEPTH-1:0] t_vec;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [FIELD_W-1:0] req_key;
        logic [FIELD_W-1:0] req_value;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic               found;
        logic [FIELD_W-1:0] out_key;
        logic [FIELD_W-1:0] out_value;
    } t_rsp;

    // match results from the key and value compare arrays
    typedef struct packed {
        t_vec key_vec;   // every valid entry whose key matches
        t_vec val_vec;   // every valid entry whose value matches
        t_vec key_oh;    // lowest of key_vec
        t_vec val_oh;    // lowest of val_vec
        logic key_hit;
        logic val_hit;
        t_key hit_key;   // key of the value match
        t_val hit_value; // value of the key match
    } t_match;

    function automatic t_vec lowest_one(input t_vec v);
        return v & (~v + t_vec'(1));
    endfunction

endpackage

`default_nettype wire

// ===== design/bmt_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bmt_req_if;
    logic          valid;
    logic          ready;
    bmt_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface bmt_rsp_if;
    logic          valid;
    logic          ready;
    bmt_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/bidirectional_map_table.sv =====
// Bidirectional map table: one-to-one key/value store with parallel match
// on keys and on values.
//
// Channels: i_req carries func, req_key and req_value; o_rsp carries status,
// found, out_key and out_value. Both use valid/ready; an item moves on a
// clock edge where both are high. Every request gives exactly one response,
// in request order.
//
// A request passes through the input register, then compare/update into the
// response register.
// Throughput: one item per cycle unless the receiver stalls, set by the
// compare of all entries with the request and the same-cycle table write.
//
// Reset (i_rst_n low, synchronous): all entry valid bits clear, so the table
// is empty; both pipeline registers are emptied.
// Receiver stall: the response register holds its item; one more request
// may be taken into the input register, then i_req.ready drops until the
// receiver takes the response. The table is only updated as a request
// moves into the response register, so stalls never change results.
`timescale 1ns / 1ps
`default_nettype none

module bidirectional_map_table (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bmt_req_if.sink     i_req,
    bmt_rsp_if.source   o_rsp
);

    logic          r_req_valid;
    bmt_pkg::t_req r_req;
    logic          r_rsp_valid;
    bmt_pkg::t_rsp r_rsp;
    bmt_pkg::t_rsp n_rsp;

    bmt_pkg::t_key r_entry_key [bmt_pkg::TABLE_DEPTH];
    bmt_pkg::t_val r_entry_value [bmt_pkg::TABLE_DEPTH];
    bmt_pkg::t_vec r_entry_valid;
    bmt_pkg::t_vec n_entry_valid;

    logic           advance;
    logic           process;
    bmt_pkg::t_key  req_key;
    bmt_pkg::t_val  req_value;
    bmt_pkg::t_match match;
    bmt_pkg::t_vec  rm_vec;
    bmt_pkg::t_vec  valid_rm;
    bmt_pkg::t_vec  free_oh;
    logic           free_any;
    logic           dup;
    logic           ins_op;
    logic           write_en;

    assign advance     = !r_rsp_valid || o_rsp.ready;
    assign process     = r_req_valid && advance;
    assign i_req.ready = !r_req_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_req_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req <= i_req.payload;
        end
    end

    assign req_key   = r_req.req_key[bmt_pkg::KEY_W-1:0];
    assign req_value = r_req.req_value[bmt_pkg::VAL_W-1:0];

    bmt_match u_match (
        .i_entry_key   (r_entry_key),
        .i_entry_value (r_entry_value),
        .i_entry_valid (r_entry_valid),
        .i_key         (req_key),
        .i_value       (req_value),
        .o_match       (match)
    );

    always_comb begin
        case (r_req.func)
            bmt_pkg::OP_REMOVE_KEY, bmt_pkg::OP_UPDATE: begin
                rm_vec = match.key_oh;
            end
            bmt_pkg::OP_REMOVE_VALUE: begin
                rm_vec = match.val_oh;
            end
            default: begin
                rm_vec = '0;
            end
        endcase
    end

    // update frees the old pair before looking for a slot and duplicates
    assign valid_rm = r_entry_valid & ~rm_vec;
    assign free_oh  = bmt_pkg::lowest_one(~valid_rm);
    assign free_any = |(~valid_rm);
    assign dup      = (|(match.key_vec & ~rm_vec)) || (|(match.val_vec & ~rm_vec));
    assign ins_op   = (r_req.func == bmt_pkg::OP_INSERT) || (r_req.func == bmt_pkg::OP_UPDATE);
    assign write_en = process && ins_op && !dup && free_any;

    always_comb begin
        if (r_req.func == bmt_pkg::OP_CLEAR) begin
            n_entry_valid = '0;
        end else begin
            n_entry_valid = valid_rm | (write_en ? free_oh : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
        end else if (process) begin
            r_entry_valid <= n_entry_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < bmt_pkg::TABLE_DEPTH; i++) begin
            if (write_en && free_oh[i]) begin
                r_entry_key[i]   <= req_key;
                r_entry_value[i] <= req_value;
            end
        end
    end

    always_comb begin
        n_rsp = '0;
        case (r_req.func)
            bmt_pkg::OP_INSERT, bmt_pkg::OP_UPDATE: begin
                if (dup) begin
                    n_rsp.status = bmt_pkg::ST_DUP;
                end else if (!free_any) begin
                    n_rsp.status = bmt_pkg::ST_FULL;
                end else begin
                    n_rsp.status = bmt_pkg::ST_OK;
                end
                n_rsp.found = (r_req.func == bmt_pkg::OP_UPDATE) && match.key_hit;
            end
            bmt_pkg::OP_REMOVE_KEY: begin
                n_rsp.found = match.key_hit;
            end
            bmt_pkg::OP_REMOVE_VALUE: begin
                n_rsp.found = match.val_hit;
            end
            bmt_pkg::OP_GET_KEY: begin
                n_rsp.found     = match.key_hit;
                n_rsp.status    = match.key_hit ? bmt_pkg::ST_OK : bmt_pkg::ST_MISS;
                n_rsp.out_value = bmt_pkg::FIELD_W'(match.hit_value);
            end
            bmt_pkg::OP_GET_VALUE: begin
                n_rsp.found   = match.val_hit;
                n_rsp.status  = match.val_hit ? bmt_pkg::ST_OK : bmt_pkg::ST_MISS;
                n_rsp.out_key = bmt_pkg::FIELD_W'(match.hit_key);
            end
            default: begin
                n_rsp = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (advance) begin
            r_rsp_valid <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

endmodule

`default_nettype wire

// ===== design/bmt_match.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmt_match (
    input  bmt_pkg::t_key   i_entry_key [bmt_pkg::TABLE_DEPTH],
    input  bmt_pkg::t_val   i_entry_value [bmt_pkg::TABLE_DEPTH],
    input  bmt_pkg::t_vec   i_entry_valid,
    input  bmt_pkg::t_key   i_key,
    input  bmt_pkg::t_val   i_value,
    output bmt_pkg::t_match o_match
);

    bmt_pkg::t_vec key_vec;
    bmt_pkg::t_vec val_vec;
    bmt_pkg::t_vec key_oh;
    bmt_pkg::t_vec val_oh;
    bmt_pkg::t_key hit_key;
    bmt_pkg::t_val hit_value;

    always_comb begin
        for (int i = 0; i < bmt_pkg::TABLE_DEPTH; i++) begin
            key_vec[i] = i_entry_valid[i] && (i_entry_key[i] == i_key);
            val_vec[i] = i_entry_valid[i] && (i_entry_value[i] == i_value);
        end
    end

    assign key_oh = bmt_pkg::lowest_one(key_vec);
    assign val_oh = bmt_pkg::lowest_one(val_vec);

    // one-hot AND-OR select of the partner field
    always_comb begin
        hit_key   = '0;
        hit_value = '0;
        for (int i = 0; i < bmt_pkg::TABLE_DEPTH; i++) begin
            hit_key   = hit_key | (val_oh[i] ? i_entry_key[i] : '0);
            hit_value = hit_value | (key_oh[i] ? i_entry_value[i] : '0);
        end
    end

    always_comb begin
        o_match.key_vec   = key_vec;
        o_match.val_vec   = val_vec;
        o_match.key_oh    = key_oh;
        o_match.val_oh    = val_oh;
        o_match.key_hit   = |key_vec;
        o_match.val_hit   = |val_vec;
        o_match.hit_key   = hit_key;
        o_match.hit_value = hit_value;
    end

endmodule

`default_nettype wire

// ===== design/bmt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "bidirectional_map_table_assert.svh"

module bmt_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_req_valid,
    input wire logic           i_req_ready,
    input wire logic           i_rsp_valid,
    input wire logic           i_rsp_ready,
    input wire bmt_pkg::t_rsp  i_rsp
);

    `BMT_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp), "response changed while stalled")

    // with no response pending the pipeline cannot be backed up
    `BMT_ASSERT_IMP(a_ready_when_drained, i_clk, i_rst_n, !i_rsp_valid, i_req_ready, "request not ready with empty output")

    `BMT_ASSERT_IMP(a_miss_clean, i_clk, i_rst_n, i_rsp_valid && (i_rsp.status == bmt_pkg::ST_MISS), !i_rsp.found && (i_rsp.out_key == '0) && (i_rsp.out_value == '0), "miss carries data")

    // at most one partner field is returned per item
    `BMT_ASSERT_IMP(a_one_partner, i_clk, i_rst_n, i_rsp_valid, (i_rsp.out_key == '0) || (i_rsp.out_value == '0), "both partner fields set")

endmodule

bind bidirectional_map_table bmt_checker u_bmt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.payload)
);

`default_nettype wire
